@@ sv/lj_pair_force_accumulator_defines.svh @@
// ----------------------------------------------------------------------------
// lj pair force accumulator assertion macros
// shared same-cycle and next-cycle implication property forms
// ----------------------------------------------------------------------------
`ifndef LJ_PAIR_FORCE_ACCUMULATOR_DEFINES_SVH
`define LJ_PAIR_FORCE_ACCUMULATOR_DEFINES_SVH

// same-cycle implication
`define LJPFA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LJPFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ljpfa_pkg.sv @@
// ----------------------------------------------------------------------------
// ljpfa_pkg
// types and constants of the lennard-jones pair force accumulator
// ----------------------------------------------------------------------------
package ljpfa_pkg;

    localparam int LJPFA_POS_FRAC_BITS = 16;
    localparam int LJPFA_FORCE_WIDTH   = 48;
    localparam int LJPFA_DIST_BITS     = 28;
    localparam int LJPFA_R2_WIDTH      = 2 * LJPFA_DIST_BITS + 2;

    localparam logic [31:0] LJPFA_CUTOFF_RESET = 32'd409600;
    localparam logic [63:0] LJPFA_ONE_Q32      = 64'h0000_0001_0000_0000;
    localparam logic [63:0] LJPFA_DIV24_LIMIT  = 64'h0AAA_AAAA_AAAA_AAAA;

    typedef struct packed {
        logic signed [31:0] centre_x;
        logic signed [31:0] centre_y;
        logic signed [31:0] centre_z;
        logic signed [31:0] neighbour_x;
        logic signed [31:0] neighbour_y;
        logic signed [31:0] neighbour_z;
        logic               pair_present;
        logic               last_of_atom;
    } t_in_item;

    typedef struct packed {
        logic signed [LJPFA_FORCE_WIDTH-1:0] force_x;
        logic signed [LJPFA_FORCE_WIDTH-1:0] force_y;
        logic signed [LJPFA_FORCE_WIDTH-1:0] force_z;
        logic                                saturated;
    } t_result;

    typedef struct packed {
        logic [2:0][LJPFA_DIST_BITS-1:0] mag;
        logic [2:0]                      pos;
        logic [2:0]                      nz;
        logic                            do_pair;
        logic                            last;
    } t_pair;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

@@ sv/ljpfa_front.sv @@
// ----------------------------------------------------------------------------
// ljpfa_front
// forms distance vectors, drops far pairs and empty items, fills the queue
// ----------------------------------------------------------------------------
module ljpfa_front
    import ljpfa_pkg::*;
(
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_data,
    output logic     o_push_valid,
    input  logic     i_push_ready,
    output t_pair    o_push_data
);

    logic [2:0][31:0] w_c;
    logic [2:0][31:0] w_n;
    logic [2:0][32:0] w_d;
    logic [2:0][32:0] w_abs;
    logic [2:0]       w_far;

    assign w_c = {i_in_data.centre_z, i_in_data.centre_y, i_in_data.centre_x};
    assign w_n = {i_in_data.neighbour_z, i_in_data.neighbour_y, i_in_data.neighbour_x};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_d[k]   = {w_n[k][31], w_n[k]} - {w_c[k][31], w_c[k]};
            w_abs[k] = w_d[k][32] ? (~w_d[k] + 33'd1) : w_d[k];
            w_far[k] = |w_abs[k][32:LJPFA_DIST_BITS];
            o_push_data.mag[k] = w_abs[k][LJPFA_DIST_BITS-1:0];
            o_push_data.nz[k]  = |w_d[k];
            o_push_data.pos[k] = !w_d[k][32] && (|w_d[k]);
        end
        o_push_data.do_pair = i_in_data.pair_present && !(|w_far);
        o_push_data.last    = i_in_data.last_of_atom;
    end

    assign o_in_ready   = i_push_ready;
    assign o_push_valid = i_in_valid && (o_push_data.do_pair || o_push_data.last);

endmodule

@@ sv/ljpfa_queue.sv @@
// ----------------------------------------------------------------------------
// ljpfa_queue
// two-entry queue between the classifying front and the arithmetic back
// ----------------------------------------------------------------------------
module ljpfa_queue
    import ljpfa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push_valid,
    output logic    o_push_ready,
    input  t_pair   i_push_data,
    output logic    o_pop_valid,
    input  logic    i_pop_ready,
    output t_pair   o_pop_data,
    output t_q_stat o_stat
);

    t_pair      r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       n_wr;
    logic       n_rd;
    logic [1:0] n_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_data   = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

    assign w_push = i_push_valid && o_push_ready;
    assign w_pop  = i_pop_ready && o_pop_valid;

    always_comb begin
        n_wr  = w_push ? ~r_wr : r_wr;
        n_rd  = w_pop ? ~r_rd : r_rd;
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

@@ sv/ljpfa_back.sv @@
// ----------------------------------------------------------------------------
// ljpfa_back
// per-pair sequencer: r2, cutoff, serial divide, q.32 products, force sums
// ----------------------------------------------------------------------------
module ljpfa_back
    import ljpfa_pkg::*;
#(
    parameter int POSITION_FRACTION_BITS = LJPFA_POS_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_cutoff,
    input  logic        i_pop_valid,
    output logic        o_pop_ready,
    input  t_pair       i_pop_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_result     o_out_data
);

    localparam int FW  = LJPFA_FORCE_WIDTH;
    localparam int R2W = LJPFA_R2_WIDTH;
    localparam int SHR = (2 * POSITION_FRACTION_BITS >= 32) ? 2 * POSITION_FRACTION_BITS - 32 : 0;
    localparam int SHL = (2 * POSITION_FRACTION_BITS < 32) ? 32 - 2 * POSITION_FRACTION_BITS : 0;
    localparam logic [63:0]   FMAX64 = (64'd1 << (FW - 1)) - 64'd1;
    localparam logic [FW-1:0] FMAX   = FMAX64[FW-1:0];
    localparam logic [FW-1:0] FMIN   = {1'b1, {(FW-1){1'b0}}};

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_SQ    = 12'b0000_0000_0010,
        S_SQADD = 12'b0000_0000_0100,
        S_CMP   = 12'b0000_0000_1000,
        S_DIV   = 12'b0000_0001_0000,
        S_MUL   = 12'b0000_0010_0000,
        S_MADD  = 12'b0000_0100_0000,
        S_MFIN  = 12'b0000_1000_0000,
        S_TERM  = 12'b0001_0000_0000,
        S_ACC   = 12'b0010_0000_0000,
        S_FIN   = 12'b0100_0000_0000,
        S_EMIT  = 12'b1000_0000_0000
    } t_state;

    typedef enum logic [2:0] {
        P_IR4,
        P_IR6,
        P_IR8,
        P_MAG,
        P_TERM
    } t_phase;

    t_state            r_state, n_state;
    t_pair             r_ent, n_ent;
    logic [1:0]        r_cnt, n_cnt;
    logic [R2W-1:0]    r_r2, n_r2;
    logic [63:0]       r_s, n_s;
    logic [64:0]       r_rem, n_rem;
    logic [63:0]       r_q, n_q;
    logic [5:0]        r_dcnt, n_dcnt;
    logic [63:0]       r_ma, n_ma;
    logic [63:0]       r_mb, n_mb;
    logic [1:0]        r_mstep, n_mstep;
    logic [63:0]       r_p, n_p;
    logic [1:0]        r_psh, n_psh;
    logic              r_pv, n_pv;
    logic [127:0]      r_acc, n_acc;
    t_phase            r_phase, n_phase;
    logic [63:0]       r_ir4, n_ir4;
    logic [63:0]       r_tm, n_tm;
    logic              r_tpos, n_tpos;
    logic              r_csat, n_csat;
    logic [63:0]       r_c, n_c;
    logic [FW-1:0]     r_term, n_term;
    logic [FW-1:0]     r_sum [3];
    logic [FW-1:0]     n_sum [3];
    logic              r_seen, n_seen;
    t_result           r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic [31:0]  w_opa;
    logic [31:0]  w_opb;
    logic [63:0]  w_prod;
    logic [127:0] w_padd;
    logic [63:0]  w_cut;
    logic [63:0]  w_s;
    logic [64:0]  w_trial;
    logic         w_qbit;
    logic [63:0]  w_res;
    logic         w_msat;
    logic [63:0]  w_two6;
    logic [63:0]  w_tm;
    logic         w_big;
    logic [FW-1:0] w_m;
    logic [FW:0]   w_sum;

    assign o_pop_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        if (r_state == S_SQ) begin
            w_opa = {{(32-LJPFA_DIST_BITS){1'b0}}, r_ent.mag[r_cnt]};
            w_opb = {{(32-LJPFA_DIST_BITS){1'b0}}, r_ent.mag[r_cnt]};
        end else begin
            w_opa = r_mstep[0] ? r_ma[63:32] : r_ma[31:0];
            w_opb = r_mstep[1] ? r_mb[63:32] : r_mb[31:0];
        end
        w_prod  = w_opa * w_opb;
        w_padd  = r_pv ? ({64'd0, r_p} << {r_psh, 5'd0}) : 128'd0;
        w_cut   = {32'd0, i_cutoff} << POSITION_FRACTION_BITS;
        w_s     = ({{(64-R2W){1'b0}}, r_r2} >> SHR) << SHL;
        w_trial = {r_rem[63:0], 1'b1};
        w_qbit  = (w_trial >= {1'b0, r_s});
        w_msat  = |r_acc[127:96];
        w_res   = w_msat ? {64{1'b1}} : r_acc[95:32];
        w_two6  = w_res[63] ? {64{1'b1}} : {w_res[62:0], 1'b0};
        w_tm    = (w_two6 >= LJPFA_ONE_Q32) ? (w_two6 - LJPFA_ONE_Q32)
                                            : (LJPFA_ONE_Q32 - w_two6);
        w_big   = r_csat || w_msat || (w_res > FMAX64);
        w_m     = w_big ? FMAX : w_res[FW-1:0];
        w_sum   = {r_sum[r_cnt][FW-1], r_sum[r_cnt]} + {r_term[FW-1], r_term};
    end

    always_comb begin
        n_state     = r_state;
        n_ent       = r_ent;
        n_cnt       = r_cnt;
        n_r2        = r_r2;
        n_s         = r_s;
        n_rem       = r_rem;
        n_q         = r_q;
        n_dcnt      = r_dcnt;
        n_ma        = r_ma;
        n_mb        = r_mb;
        n_mstep     = r_mstep;
        n_p         = r_p;
        n_psh       = r_psh;
        n_pv        = r_pv;
        n_acc       = r_acc;
        n_phase     = r_phase;
        n_ir4       = r_ir4;
        n_tm        = r_tm;
        n_tpos      = r_tpos;
        n_csat      = r_csat;
        n_c         = r_c;
        n_term      = r_term;
        n_sum       = r_sum;
        n_seen      = r_seen;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_pop_valid) begin
                    n_ent = i_pop_data;
                    if (i_pop_data.do_pair) begin
                        n_r2    = '0;
                        n_cnt   = 2'd0;
                        n_pv    = 1'b0;
                        n_state = S_SQ;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_SQ: begin
                n_p  = w_prod;
                n_pv = 1'b1;
                if (r_pv) begin
                    n_r2 = r_r2 + r_p[R2W-1:0];
                end
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd2) begin
                    n_state = S_SQADD;
                end
            end
            S_SQADD: begin
                n_r2    = r_r2 + r_p[R2W-1:0];
                n_pv    = 1'b0;
                n_state = S_CMP;
            end
            S_CMP: begin
                n_tpos = 1'b1;
                n_csat = 1'b0;
                if ({{(64-R2W){1'b0}}, r_r2} >= w_cut) begin
                    n_state = S_FIN;
                end else if (w_s == 64'd0) begin
                    n_csat  = 1'b1;
                    n_seen  = 1'b1;
                    n_c     = {64{1'b1}};
                    n_cnt   = 2'd0;
                    n_state = S_TERM;
                end else begin
                    n_s     = w_s;
                    n_rem   = '0;
                    n_q     = '0;
                    n_dcnt  = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem  = w_qbit ? (w_trial - {1'b0, r_s}) : w_trial;
                n_q    = {r_q[62:0], w_qbit};
                n_dcnt = r_dcnt + 6'd1;
                if (r_dcnt == 6'd63) begin
                    n_ma    = {r_q[62:0], w_qbit};
                    n_mb    = {r_q[62:0], w_qbit};
                    n_phase = P_IR4;
                    n_mstep = 2'd0;
                    n_acc   = '0;
                    n_pv    = 1'b0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_p     = w_prod;
                n_psh   = {1'b0, r_mstep[0]} + {1'b0, r_mstep[1]};
                n_pv    = 1'b1;
                n_acc   = r_acc + w_padd;
                n_mstep = r_mstep + 2'd1;
                if (r_mstep == 2'd3) begin
                    n_state = S_MADD;
                end
            end
            S_MADD: begin
                n_acc   = r_acc + w_padd;
                n_pv    = 1'b0;
                n_state = S_MFIN;
            end
            S_MFIN: begin
                n_mstep = 2'd0;
                n_acc   = '0;
                n_pv    = 1'b0;
                case (r_phase)
                    P_IR4: begin
                        n_csat  = r_csat || w_msat;
                        n_ir4   = w_res;
                        n_ma    = w_res;
                        n_mb    = r_q;
                        n_phase = P_IR6;
                        n_state = S_MUL;
                    end
                    P_IR6: begin
                        n_csat = r_csat || w_msat || w_res[63];
                        n_tpos = (w_two6 >= LJPFA_ONE_Q32);
                        n_tm   = w_tm;
                        if (w_tm == 64'd0) begin
                            n_state = S_FIN;
                        end else begin
                            n_ma    = r_ir4;
                            n_mb    = r_ir4;
                            n_phase = P_IR8;
                            n_state = S_MUL;
                        end
                    end
                    P_IR8: begin
                        n_csat  = r_csat || w_msat;
                        n_ma    = w_res;
                        n_mb    = r_tm;
                        n_phase = P_MAG;
                        n_state = S_MUL;
                    end
                    P_MAG: begin
                        if (w_res > LJPFA_DIV24_LIMIT) begin
                            n_csat = 1'b1;
                            n_c    = {64{1'b1}};
                        end else begin
                            n_csat = r_csat || w_msat;
                            n_c    = (w_res << 4) + (w_res << 3);
                        end
                        n_cnt   = 2'd0;
                        n_state = S_TERM;
                    end
                    P_TERM: begin
                        if (w_big && r_ent.nz[r_cnt]) begin
                            n_seen = 1'b1;
                        end
                        if (!r_ent.nz[r_cnt]) begin
                            n_term = '0;
                        end else if (r_tpos == r_ent.pos[r_cnt]) begin
                            n_term = ~w_m + {{(FW-1){1'b0}}, 1'b1};
                        end else begin
                            n_term = w_m;
                        end
                        n_state = S_ACC;
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_TERM: begin
                n_ma    = r_c;
                n_mb    = {{(64-LJPFA_DIST_BITS){1'b0}}, r_ent.mag[r_cnt]};
                n_phase = P_TERM;
                n_mstep = 2'd0;
                n_acc   = '0;
                n_pv    = 1'b0;
                n_state = S_MUL;
            end
            S_ACC: begin
                if (w_sum[FW] != w_sum[FW-1]) begin
                    n_sum[r_cnt] = w_sum[FW] ? FMIN : FMAX;
                    n_seen       = 1'b1;
                end else begin
                    n_sum[r_cnt] = w_sum[FW-1:0];
                end
                if (r_cnt == 2'd2) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt   = r_cnt + 2'd1;
                    n_state = S_TERM;
                end
            end
            S_FIN: begin
                n_state = r_ent.last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.force_x   = r_sum[0];
                    n_out.force_y   = r_sum[1];
                    n_out.force_z   = r_sum[2];
                    n_out.saturated = r_seen;
                    n_out_valid     = 1'b1;
                    n_sum[0]        = '0;
                    n_sum[1]        = '0;
                    n_sum[2]        = '0;
                    n_seen          = 1'b0;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
            r_sum[0]    <= '0;
            r_sum[1]    <= '0;
            r_sum[2]    <= '0;
            r_seen      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pv        <= n_pv;
            r_out_valid <= n_out_valid;
            r_sum       <= n_sum;
            r_seen      <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent   <= n_ent;
        r_cnt   <= n_cnt;
        r_r2    <= n_r2;
        r_s     <= n_s;
        r_rem   <= n_rem;
        r_q     <= n_q;
        r_dcnt  <= n_dcnt;
        r_ma    <= n_ma;
        r_mb    <= n_mb;
        r_mstep <= n_mstep;
        r_p     <= n_p;
        r_psh   <= n_psh;
        r_acc   <= n_acc;
        r_phase <= n_phase;
        r_ir4   <= n_ir4;
        r_tm    <= n_tm;
        r_tpos  <= n_tpos;
        r_csat  <= n_csat;
        r_c     <= n_c;
        r_term  <= n_term;
        r_out   <= n_out;
    end

endmodule

@@ sv/lj_pair_force_accumulator.sv @@
// ----------------------------------------------------------------------------
// lj_pair_force_accumulator
// lennard-jones 12-6 pair force accumulation with cutoff, per centre atom
// ----------------------------------------------------------------------------
// channels: input pairs (i_in_valid / o_in_ready / i_in_data), one result per
// atom (o_out_valid / i_out_ready / o_out_data), and a cutoff write channel
// (i_cfg_valid / o_cfg_ready / i_cfg_data) that is always ready.
// the front takes a transaction and queues it (two entries);
// empty items and too-distant pairs that do not end an atom are dropped there.
// the back works on one pair at a time: a pair inside the cutoff goes through
// the 64-step restoring divider for 1/r^2 and the single shared 32x32
// multiplier (4 partial products per q.32 product, 7 products).
// a pair beyond the cutoff is squared, compared and finished with no divide.
// a result leaves through an output register after its last pair finishes;
// a stalled receiver holds that register and the back waits only when it has
// the next result ready.
// reset: cutoff returns to 6.25, sums and saturation flag clear, queue empties.
// ----------------------------------------------------------------------------
`include "lj_pair_force_accumulator_defines.svh"

module lj_pair_force_accumulator
    import ljpfa_pkg::*;
#(
    parameter int POSITION_FRACTION_BITS = LJPFA_POS_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_result     o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    logic [31:0] r_cutoff;
    logic [31:0] n_cutoff;
    logic        w_push_valid;
    logic        w_push_ready;
    t_pair       w_push_data;
    logic        w_pop_valid;
    logic        w_pop_ready;
    t_pair       w_pop_data;
    t_q_stat     w_q_stat;

    assign o_cfg_ready = 1'b1;
    assign n_cutoff    = (i_cfg_valid && o_cfg_ready) ? i_cfg_data : r_cutoff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= LJPFA_CUTOFF_RESET;
        end else begin
            r_cutoff <= n_cutoff;
        end
    end

    ljpfa_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_data  (w_push_data)
    );

    ljpfa_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data),
        .o_stat       (w_q_stat)
    );

    ljpfa_back #(
        .POSITION_FRACTION_BITS (POSITION_FRACTION_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cutoff    (r_cutoff),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_data  (w_pop_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    `LJPFA_ASSERT_IMP(a_full_blocks_input, i_clk, i_rst_n, w_q_stat.full, !o_in_ready, "input ready while queue full")
    `LJPFA_ASSERT_NEXT(a_push_fills_queue, i_clk, i_rst_n, w_push_valid && w_push_ready, !w_q_stat.empty, "queue empty after push")

endmodule
